/* design/raff_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package raff_pkg;

  localparam int MaxSlots = 4096;
  localparam int MaxRanges = 64;
  localparam int SlotW = 12;
  localparam int LenW = 13;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_SCAN,
    S_SHIFT_UP,
    S_INSERT,
    S_MERGE_RD,
    S_MERGE,
    S_SHIFT_DN,
    S_FOLD_RD,
    S_FOLD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic check;
    logic rd_req;
    logic scan_step;
    logic shift_up;
    logic insert;
    logic merge_rd;
    logic merge;
    logic shift_dn;
    logic fold_rd;
    logic fold;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic overflow;
    logic is_alloc;
    logic scan_hit;
    logic scan_end;
    logic shift_up_end;
    logic do_merge;
    logic merge_is_prev;
    logic shift_dn_end;
    logic fold_hit;
  } stat_t;

endpackage
`default_nettype wire

/* design/raff_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module raff_ctrl
  import raff_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.reject || stat.overflow) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_RD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.is_alloc) begin
          if (stat.scan_hit) state_nxt = stat.do_merge ? S_SHIFT_DN : S_DONE;
          else if (stat.scan_end) state_nxt = S_DONE;
          else state_nxt = S_RD;
        end else begin
          if (stat.scan_hit || stat.scan_end) state_nxt = S_SHIFT_UP;
          else state_nxt = S_RD;
        end
      end
      S_SHIFT_UP: if (stat.shift_up_end) state_nxt = S_INSERT;
      S_INSERT:   state_nxt = S_MERGE_RD;
      S_MERGE_RD: state_nxt = S_MERGE;
      S_MERGE: begin
        if (stat.do_merge) state_nxt = S_SHIFT_DN;
        else if (stat.merge_is_prev) state_nxt = S_MERGE_RD;
        else state_nxt = S_FOLD_RD;
      end
      S_SHIFT_DN: begin
        if (stat.shift_dn_end) state_nxt = stat.is_alloc ? S_DONE : S_MERGE_RD;
      end
      S_FOLD_RD:  state_nxt = S_FOLD;
      S_FOLD:     state_nxt = stat.fold_hit ? S_FOLD_RD : S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:     cmd.load = start;
      S_CHECK:    cmd.check = 1'b1;
      S_RD:       cmd.rd_req = 1'b1;
      S_SCAN:     cmd.scan_step = 1'b1;
      S_SHIFT_UP: cmd.shift_up = 1'b1;
      S_INSERT:   cmd.insert = 1'b1;
      S_MERGE_RD: cmd.merge_rd = 1'b1;
      S_MERGE:    cmd.merge = 1'b1;
      S_SHIFT_DN: cmd.shift_dn = 1'b1;
      S_FOLD_RD:  cmd.fold_rd = 1'b1;
      S_FOLD:     cmd.fold = 1'b1;
      S_DONE:     cmd.finish = out_free;
      default:    cmd = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

/* design/raff_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module raff_dp
  import raff_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  input  wire logic              cfg_wr,
  input  wire logic [LenW-1:0]   cfg_data,
  input  wire logic              in_kind,
  input  wire logic [LenW-1:0]   in_run_length,
  input  wire logic [SlotW-1:0]  in_first_slot,
  output stat_t                  stat,
  output logic [1:0]             res_status,
  output logic [SlotW-1:0]       res_slot,
  output logic [LenW-1:0]        res_top,
  output logic [CntW-1:0]        res_count
);

  // Entries hold {start, length}.
  logic [SlotW-1:0] mem_start [MaxRanges];
  logic [LenW-1:0]  mem_len   [MaxRanges];

  logic [LenW-1:0]  cap_r;
  logic [CntW-1:0]  count_r;
  logic [LenW-1:0]  bump_r;
  logic             kind_r;
  logic [LenW-1:0]  len_r;
  logic [SlotW-1:0] slot_r;
  logic [1:0]       status_r;
  logic [SlotW-1:0] grant_r;
  logic [CntW-1:0]  idx_r;
  logic [CntW-1:0]  pos_r;
  logic [SlotW-1:0] a_start_r, b_start_r;
  logic [LenW-1:0]  a_len_r, b_len_r;

  logic [LenW-1:0]  eff_cap;
  logic [LenW:0]    a_end, b_end, max_end;
  logic [LenW-1:0]  bump_sum;
  logic             rd_en;
  logic [IdxW-1:0]  rd_a, rd_b;
  logic             wr_en;
  logic [IdxW-1:0]  wr_a;
  logic [SlotW-1:0] wr_s;
  logic [LenW-1:0]  wr_l;

  assign eff_cap = (cap_r > LenW'(MaxSlots)) ? LenW'(MaxSlots) : cap_r;
  assign a_end = {1'b0, LenW'(a_start_r)} + {1'b0, a_len_r};
  assign b_end = {1'b0, LenW'(b_start_r)} + {1'b0, b_len_r};
  assign max_end = (a_end > b_end) ? a_end : b_end;
  assign bump_sum = bump_r + len_r;

  // Port b always reads entry idx+1. Port a reads entry idx in S_RD and S_MERGE_RD,
  // and during shifts the entry that the next shift write copies from.
  always_comb begin
    rd_en = cmd.rd_req | cmd.merge_rd | cmd.fold_rd | cmd.shift_up | cmd.shift_dn |
            cmd.scan_step | cmd.merge;
    rd_a = idx_r[IdxW-1:0];
    rd_b = IdxW'(idx_r + 7'd1);
    if (cmd.scan_step) rd_a = kind_r ? IdxW'(count_r - 7'd1) : IdxW'(idx_r + 7'd1);
    if (cmd.merge)     rd_a = IdxW'(idx_r + 7'd2);
    if (cmd.shift_up)  rd_a = IdxW'(idx_r - 7'd2);
    if (cmd.shift_dn)  rd_a = IdxW'(idx_r + 7'd3);
    if (cmd.fold_rd)   rd_a = IdxW'(count_r - 7'd1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      a_start_r <= mem_start[rd_a];
      a_len_r   <= mem_len[rd_a];
      b_start_r <= mem_start[rd_b];
      b_len_r   <= mem_len[rd_b];
    end
    if (wr_en) begin
      mem_start[wr_a] <= wr_s;
      mem_len[wr_a]   <= wr_l;
    end
  end

  always_comb begin
    stat = '0;
    stat.is_alloc = !kind_r;
    stat.reject = (len_r == '0) ||
                  (kind_r && ((LenW'(slot_r) >= eff_cap) ||
                              (len_r > eff_cap - LenW'(slot_r))));
    stat.overflow = kind_r && (count_r >= CntW'(MaxRanges));
    stat.scan_end = (idx_r + 7'd1 >= count_r) || (count_r == '0);
    stat.scan_hit = (count_r != '0) &&
                    (kind_r ? (a_start_r >= slot_r) : (a_len_r >= len_r));
    stat.do_merge = cmd.scan_step ? (a_len_r == len_r)
                  : ((idx_r + 7'd1 < count_r) && (a_end >= {2'b0, b_start_r}));
    stat.shift_up_end = (idx_r <= pos_r);
    stat.shift_dn_end = (idx_r + 7'd2 >= count_r);
    stat.merge_is_prev = (idx_r + 7'd1 == pos_r);
    stat.fold_hit = (count_r != '0) && (a_end == {1'b0, bump_r});
  end

  always_comb begin
    wr_en = 1'b0;
    wr_a  = idx_r[IdxW-1:0];
    wr_s  = a_start_r;
    wr_l  = a_len_r;
    if (cmd.scan_step && !kind_r && stat.scan_hit && !stat.do_merge) begin
      wr_en = 1'b1;
      wr_s  = SlotW'(LenW'(a_start_r) + len_r);
      wr_l  = a_len_r - len_r;
    end
    if (cmd.shift_up && !stat.shift_up_end) begin
      wr_en = 1'b1;
      wr_a  = idx_r[IdxW-1:0];
    end
    if (cmd.insert) begin
      wr_en = 1'b1;
      wr_a  = pos_r[IdxW-1:0];
      wr_s  = slot_r;
      wr_l  = len_r;
    end
    if (cmd.merge && stat.do_merge) begin
      wr_en = 1'b1;
      wr_s  = a_start_r;
      wr_l  = LenW'(max_end - {1'b0, LenW'(a_start_r)});
    end
    if (cmd.shift_dn && !stat.shift_dn_end) begin
      wr_en = 1'b1;
      wr_a  = IdxW'(idx_r + 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= LenW'(MaxSlots);
      count_r <= '0;
      bump_r  <= '0;
    end else if (cfg_wr) begin
      cap_r   <= cfg_data;
      count_r <= '0;
      bump_r  <= '0;
    end else begin
      if (cmd.scan_step && !kind_r) begin
        if (stat.scan_hit && stat.do_merge) begin
          idx_r <= idx_r - 7'd1;
        end else if (!stat.scan_hit && stat.scan_end) begin
          if ({1'b0, bump_r} + {1'b0, len_r} > {1'b0, eff_cap}) begin
            status_r <= ST_NO_SPACE;
          end else begin
            grant_r <= bump_r[SlotW-1:0];
            bump_r  <= bump_sum;
          end
        end
        if (stat.scan_hit) grant_r <= a_start_r;
      end
      if (cmd.shift_dn && stat.shift_dn_end) count_r <= count_r - 7'd1;
      if (cmd.insert) count_r <= count_r + 7'd1;
      if (cmd.fold && stat.fold_hit) begin
        bump_r  <= LenW'(a_start_r);
        count_r <= count_r - 7'd1;
      end
    end
    if (cmd.load) begin
      kind_r   <= in_kind;
      len_r    <= in_run_length;
      slot_r   <= in_first_slot;
      status_r <= ST_OK;
      grant_r  <= '0;
      idx_r    <= '0;
    end
    if (cmd.check) begin
      if (stat.reject) status_r <= ST_REJECT;
      else if (stat.overflow) status_r <= ST_OVERFLOW;
    end
    if (cmd.scan_step) begin
      if (kind_r && (stat.scan_hit || stat.scan_end)) begin
        pos_r <= stat.scan_hit ? idx_r : count_r;
        idx_r <= count_r;
      end else if (!stat.scan_hit && !stat.scan_end) begin
        idx_r <= idx_r + 7'd1;
      end
    end
    if (cmd.shift_up && !stat.shift_up_end) idx_r <= idx_r - 7'd1;
    if (cmd.insert) idx_r <= (pos_r != '0) ? pos_r - 7'd1 : pos_r;
    if (cmd.merge) begin
      if (!stat.do_merge) begin
        if (idx_r + 7'd1 == pos_r) idx_r <= pos_r;
      end
    end
    if (cmd.merge && stat.do_merge) begin
      pos_r <= idx_r;
    end
    if (cmd.shift_dn) begin
      if (stat.shift_dn_end) idx_r <= pos_r;
      else idx_r <= idx_r + 7'd1;
    end
  end

  assign res_status = status_r;
  assign res_slot   = (kind_r || status_r != ST_OK) ? '0 : grant_r;
  assign res_top    = bump_r;
  assign res_count  = count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxRanges))
    else $error("free table count above capacity");
  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bump_r <= LenW'(MaxSlots))
    else $error("bump pointer above slot count");
  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> count_r < CntW'(MaxRanges))
    else $error("insert into full table");
`endif

endmodule
`default_nettype wire

/* design/range_allocator_first_fit_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A rejected request or a release into a full table skips the table walk; otherwise
// the time grows with the entries scanned and shifted and the merge checks and folds.
// The slowest case is a release that coalesces a full table.
// One transaction at a time: in_stall is high from acceptance until it ends.
// The output register holds a result until taken; the next result waits on it.
// Synchronous active-low reset sets capacity to 4096 and empties the free table.
module range_allocator_first_fit_top
  import raff_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_kind,
  input  wire logic [LenW-1:0]  in_run_length,
  input  wire logic [SlotW-1:0] in_first_slot,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [SlotW-1:0]      out_granted_slot,
  output logic [LenW-1:0]       out_top_of_use,
  output logic [CntW-1:0]       out_free_ranges_held,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [LenW-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;
  logic  valid_r;
  logic  start;

  logic [1:0]       res_status;
  logic [SlotW-1:0] res_slot;
  logic [LenW-1:0]  res_top;
  logic [CntW-1:0]  res_count;
  logic [1:0]       status_r;
  logic [SlotW-1:0] slot_r;
  logic [LenW-1:0]  top_r;
  logic [CntW-1:0]  count_r;

  assign in_stall = busy;
  assign start = in_valid && !busy;
  assign cfg_ready = 1'b1;

  raff_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_free(!valid_r),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  raff_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .cfg_wr(cfg_valid && cfg_ready), .cfg_data(cfg_data),
    .in_kind(in_kind), .in_run_length(in_run_length), .in_first_slot(in_first_slot),
    .stat(stat), .res_status(res_status), .res_slot(res_slot),
    .res_top(res_top), .res_count(res_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.finish) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r <= res_status;
      slot_r   <= res_slot;
      top_r    <= res_top;
      count_r  <= res_count;
    end
  end

  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_granted_slot     = slot_r;
  assign out_top_of_use       = top_r;
  assign out_free_ranges_held = count_r;

endmodule
`default_nettype wire

/* verif/tb_range_allocator_first_fit_top.sv */
`timescale 1ns / 1ps
module tb_range_allocator_first_fit_top;
  import raff_pkg::*;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam int StallLimit = 40000;

  typedef struct packed {
    logic [1:0]       status;
    logic [SlotW-1:0] granted_slot;
    logic [LenW-1:0]  top_of_use;
    logic [CntW-1:0]  free_ranges_held;
  } alloc_result_t;

  typedef struct {
    int unsigned first;
    int unsigned len;
  } run_t;

  class alloc_scoreboard;
    int unsigned free_start[MaxRanges];
    int unsigned free_len[MaxRanges];
    int unsigned free_count;
    int unsigned bump;
    int unsigned capacity;
    alloc_result_t pending[$];
    int errors;
    int results_seen;
    int status_seen[4];

    function void clear_state(int unsigned cap);
      capacity = cap;
      free_count = 0;
      bump = 0;
    endfunction

    function int unsigned cap_limit();
      return (capacity > MaxSlots) ? MaxSlots : capacity;
    endfunction

    function void drop_entry(int unsigned idx);
      for (int unsigned i = idx; i + 1 < free_count; i++) begin
        free_start[i] = free_start[i + 1];
        free_len[i] = free_len[i + 1];
      end
      free_count--;
    endfunction

    function logic [1:0] take_run(int unsigned len, output int unsigned slot);
      slot = 0;
      for (int unsigned i = 0; i < free_count; i++) begin
        if (free_len[i] >= len) begin
          slot = free_start[i];
          free_start[i] += len;
          free_len[i] -= len;
          if (free_len[i] == 0) drop_entry(i);
          return ST_OK;
        end
      end
      if (bump + len > cap_limit()) return ST_NO_SPACE;
      slot = bump;
      bump += len;
      return ST_OK;
    endfunction

    function logic [1:0] give_back(int unsigned first, int unsigned len);
      int unsigned cap, pos, cur, fin, pend, a, b, t;
      cap = cap_limit();
      if (first >= cap || len > cap - first) return ST_REJECT;
      if (free_count >= MaxRanges) return ST_OVERFLOW;
      pos = 0;
      while (pos < free_count && free_start[pos] < first) pos++;
      for (int unsigned i = free_count; i > pos; i--) begin
        free_start[i] = free_start[i - 1];
        free_len[i] = free_len[i - 1];
      end
      free_start[pos] = first;
      free_len[pos] = len;
      free_count++;
      cur = pos;
      if (cur > 0) begin
        pend = free_start[cur - 1] + free_len[cur - 1];
        if (pend >= free_start[cur]) begin
          fin = free_start[cur] + free_len[cur];
          if (pend > fin) fin = pend;
          free_len[cur - 1] = fin - free_start[cur - 1];
          drop_entry(cur);
          cur = cur - 1;
        end
      end
      while (cur + 1 < free_count &&
             free_start[cur] + free_len[cur] >= free_start[cur + 1]) begin
        a = free_start[cur] + free_len[cur];
        b = free_start[cur + 1] + free_len[cur + 1];
        fin = (a > b) ? a : b;
        free_len[cur] = fin - free_start[cur];
        drop_entry(cur + 1);
      end
      while (free_count > 0) begin
        t = free_count - 1;
        if (free_start[t] + free_len[t] != bump) break;
        bump = free_start[t];
        free_count--;
      end
      return ST_OK;
    endfunction

    function alloc_result_t note_request(logic kind, logic [LenW-1:0] len,
                                         logic [SlotW-1:0] first);
      alloc_result_t r;
      int unsigned slot;
      slot = 0;
      if (len == 0) r.status = ST_REJECT;
      else if (kind == KIND_ALLOC) r.status = take_run(len, slot);
      else r.status = give_back(first, len);
      if (r.status != ST_OK || kind != KIND_ALLOC) slot = 0;
      r.granted_slot = slot[SlotW-1:0];
      r.top_of_use = bump[LenW-1:0];
      r.free_ranges_held = free_count[CntW-1:0];
      pending.push_back(r);
      return r;
    endfunction

    function void check_result(alloc_result_t act);
      alloc_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $time, act);
        errors++;
        return;
      end
      e = pending.pop_front();
      status_seen[act.status]++;
      if (act.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
        errors++;
      end
      if (act.granted_slot !== e.granted_slot) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time,
                 e.granted_slot, act.granted_slot);
        errors++;
      end
      if (act.top_of_use !== e.top_of_use) begin
        $display("%0t: top_of_use expected %0d actual %0d", $time,
                 e.top_of_use, act.top_of_use);
        errors++;
      end
      if (act.free_ranges_held !== e.free_ranges_held) begin
        $display("%0t: free_ranges_held expected %0d actual %0d", $time,
                 e.free_ranges_held, act.free_ranges_held);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_kind;
  logic [LenW-1:0]  in_run_length;
  logic [SlotW-1:0] in_first_slot;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [SlotW-1:0] out_granted_slot;
  logic [LenW-1:0]  out_top_of_use;
  logic [CntW-1:0]  out_free_ranges_held;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LenW-1:0]  cfg_data;

  alloc_scoreboard sb;
  run_t held[$];
  int tx_idle_pct;
  int rx_stall_pct;
  int items_sent;
  int cap_writes;
  int quiet_cycles;

  range_allocator_first_fit_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_run_length(in_run_length),
    .in_first_slot(in_first_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_granted_slot(out_granted_slot),
    .out_top_of_use(out_top_of_use),
    .out_free_ranges_held(out_free_ranges_held),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_status, out_granted_slot, out_top_of_use, out_free_ranges_held});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("tb_range_allocator_first_fit_top NOT OK");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input int unsigned len, input int unsigned first,
                           output alloc_result_t exp);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_run_length = len[LenW-1:0];
    in_first_slot = first[SlotW-1:0];
    do @(posedge clk); while (in_stall);
    exp = sb.note_request(kind, len[LenW-1:0], first[SlotW-1:0]);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned cap);
    drain();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = cap[LenW-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.clear_state(cap & 13'h1fff);
    held.delete();
    cap_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic alloc_run(input int unsigned len);
    alloc_result_t r;
    run_t h;
    send_item(KIND_ALLOC, len, $urandom_range(4095), r);
    if (r.status == ST_OK) begin
      h.first = r.granted_slot;
      h.len = len;
      held.push_back(h);
    end
  endtask

  task automatic random_traffic(input int count, input int unsigned cap);
    alloc_result_t r;
    int sel, idx;
    int unsigned len, part;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 50 || held.size() == 0) begin
        if ($urandom_range(19) == 0) len = $urandom_range(cap > 0 ? cap : 1, 1);
        else len = $urandom_range(16, 1);
        alloc_run(len);
      end else if (sel < 88) begin
        idx = $urandom_range(held.size() - 1);
        part = ($urandom_range(3) == 0) ? $urandom_range(held[idx].len, 1) : held[idx].len;
        send_item(KIND_RELEASE, part, held[idx].first, r);
        held.delete(idx);
      end else if (sel < 94) begin
        send_item(KIND_RELEASE, $urandom_range(24, 1), $urandom_range(cap > 0 ? cap : 1), r);
      end else begin
        send_item($urandom_range(1), $urandom_range(8191), $urandom_range(4095), r);
      end
    end
  endtask

  initial begin
    alloc_result_t r;
    int unsigned caps[5];
    sb = new();
    sb.clear_state(MaxSlots);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ALLOC;
    in_run_length = '0;
    in_first_slot = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_idle_pct = 13;
    rx_stall_pct = 51;
    items_sent = 0;
    cap_writes = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_item(KIND_ALLOC, 0, 0, r);
    send_item(KIND_RELEASE, 0, 5, r);
    send_item(KIND_ALLOC, 4096, 4095, r);
    send_item(KIND_ALLOC, 1, 0, r);
    send_item(KIND_RELEASE, 2, 4095, r);
    send_item(KIND_RELEASE, 8191, 0, r);
    send_item(KIND_RELEASE, 4096, 0, r);
    send_item(KIND_RELEASE, 1, 4095, r);
    send_item(KIND_ALLOC, 1, 0, r);
    send_item(KIND_ALLOC, 40, 0, r);
    send_item(KIND_RELEASE, 5, 10, r);
    send_item(KIND_RELEASE, 5, 12, r);
    send_item(KIND_RELEASE, 2, 3, r);
    send_item(KIND_RELEASE, 5, 5, r);
    send_item(KIND_RELEASE, 3, 12, r);
    send_item(KIND_RELEASE, 30, 10, r);
    send_item(KIND_ALLOC, 4096, 0, r);
    write_capacity(0);
    send_item(KIND_ALLOC, 1, 0, r);
    send_item(KIND_RELEASE, 1, 0, r);
    write_capacity(1);
    send_item(KIND_ALLOC, 1, 0, r);
    send_item(KIND_ALLOC, 1, 0, r);
    send_item(KIND_RELEASE, 1, 0, r);

    write_capacity(200);
    for (int i = 0; i < 130; i++) send_item(KIND_ALLOC, 1, 0, r);
    for (int i = 0; i <= 128; i += 2) send_item(KIND_RELEASE, 1, i, r);

    caps = '{8191, 37, 4096, 1, 300};
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 51 : 0;
      rx_stall_pct = (mode == 0) ? 51 : (mode == 1) ? 13 : 0;
      foreach (caps[c]) begin
        write_capacity(caps[c]);
        random_traffic(caps[c] == 1 ? 15 : 45, (caps[c] > MaxSlots) ? MaxSlots : caps[c]);
      end
    end

    drain();
    repeat (400) @(posedge clk);
    $display("Sent %0d requests over %0d capacity settings; %0d results checked.",
             items_sent, cap_writes, sb.results_seen);
    $display("Status mix: ok %0d, no space %0d, rejected %0d, overflow %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_range_allocator_first_fit_top OK");
    end else begin
      $display("tb_range_allocator_first_fit_top NOT OK");
    end
    $finish;
  end

endmodule
